>>> sv/vasl_pkg.sv
// Shared widths, codes and helpers for the velocity slew limiter.
// No dependencies; used by velocity_accel_slew_limiter_core.
package vasl_pkg;

  // Field widths
  localparam int VEL_W   = 24;               // velocity field width
  localparam int STEP_W  = 23;               // per-tick limit register width
  localparam int DIFF_W  = VEL_W + 1;        // target minus current, signed
  localparam int ABS_W   = VEL_W + 1;        // magnitude of a difference
  localparam int SQ_W    = 2 * ABS_W;        // sum of two squares
  localparam int PROD_W  = ABS_W + STEP_W;   // |d| * max_step_xy
  localparam int MAG_W   = ABS_W + 1;        // root, after undoing the optional pre-shift
  localparam int REM_W   = ABS_W + 2;        // sqrt and divide partial remainders
  localparam int SUM_W   = DIFF_W + 2;       // current plus step, before saturation
  localparam int CMP_W   = DIFF_W + STEP_W + 1;  // z clamp compare width
  localparam int KX_W    = ABS_W + 32;       // room to test a magnitude against 2^31
  localparam int MUL_N   = (ABS_W > STEP_W) ? ABS_W : STEP_W;  // shift-add passes
  localparam int CNT_W   = $clog2(MUL_N + 1);
  localparam int CFG_IDX_W = 1;

  // Opcodes
  localparam logic OP_STEP = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP_XY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP_Z  = 1'b1;

  typedef logic signed [VEL_W-1:0] vel_t;
  typedef logic [STEP_W-1:0]       step_t;

  // Clip a wide signed sum to the velocity range
  function automatic vel_t sat_vel(input logic signed [SUM_W-1:0] v);
    logic hi_ones;
    logic hi_zeros;
    begin
      hi_ones  = &v[SUM_W-1:VEL_W-1];
      hi_zeros = ~|v[SUM_W-1:VEL_W-1];
      if (hi_ones || hi_zeros) begin
        sat_vel = v[VEL_W-1:0];
      end else if (v[SUM_W-1]) begin
        sat_vel = {1'b1, {(VEL_W-1){1'b0}}};
      end else begin
        sat_vel = {1'b0, {(VEL_W-1){1'b1}}};
      end
    end
  endfunction

endpackage

>>> sv/velocity_accel_slew_limiter_core.sv
// Velocity slew limiter: moves a stored 3D velocity toward a target each tick.
// Depends on vasl_pkg (widths, opcodes, register indexes, saturation).
//
// Usage:
//   Input words arrive on in_valid/in_ready carrying an opcode and a target
//   velocity. A step word moves the stored velocity toward the target, the xy
//   change limited by vector magnitude to max_step_xy and the z change
//   clamped to max_step_z; a load word presets the stored velocity. Each
//   input word yields exactly one result word on out_valid/out_ready.
//   Limits are written through cfg_we/cfg_index/cfg_wdata; the user must
//   write them only while idle, as the block itself does not enforce it.
// Sequence:
//   A step word runs setup, bit-serial shift-add passes for the squares and
//   |d| * max_step_xy, a bit-serial square root, a magnitude check, the two
//   parallel bit-serial dividers and commit; an unlimited step skips the
//   divide, and a load word goes from setup straight to commit.
//   One word is in flight at a time; in_ready is high in the idle state, from
//   the cycle after commit, so the next word is accepted only after commit.
// Reset and stall:
//   rst_n (synchronous, low) clears the stored velocity, the limits and the
//   output valid. A finished result is held in the output register; the next
//   word is accepted and computed while it waits, and only the commit of that
//   next result waits for out_ready.
module velocity_accel_slew_limiter_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [vasl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vasl_pkg::STEP_W-1:0]         cfg_wdata,
  // input words
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_opcode,
  input  logic signed [vasl_pkg::VEL_W-1:0]   in_target_vx,
  input  logic signed [vasl_pkg::VEL_W-1:0]   in_target_vy,
  input  logic signed [vasl_pkg::VEL_W-1:0]   in_target_vz,
  // result words
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [vasl_pkg::VEL_W-1:0]   out_vx,
  output logic signed [vasl_pkg::VEL_W-1:0]   out_vy,
  output logic signed [vasl_pkg::VEL_W-1:0]   out_vz,
  output logic                                out_xy_limited,
  output logic                                out_z_limited
);

  localparam int VEL_W  = vasl_pkg::VEL_W;
  localparam int STEP_W = vasl_pkg::STEP_W;
  localparam int DIFF_W = vasl_pkg::DIFF_W;
  localparam int ABS_W  = vasl_pkg::ABS_W;
  localparam int SQ_W   = vasl_pkg::SQ_W;
  localparam int PROD_W = vasl_pkg::PROD_W;
  localparam int MAG_W  = vasl_pkg::MAG_W;
  localparam int REM_W  = vasl_pkg::REM_W;
  localparam int SUM_W  = vasl_pkg::SUM_W;
  localparam int CMP_W  = vasl_pkg::CMP_W;
  localparam int KX_W   = vasl_pkg::KX_W;
  localparam int CNT_W  = vasl_pkg::CNT_W;
  localparam int SQT_W  = REM_W + 2;   // sqrt trial width
  localparam int DVT_W  = REM_W + 1;   // divide trial width
  localparam int LIM_W  = MAG_W + STEP_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIFF = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;

  // configuration and stored velocity
  vasl_pkg::step_t         max_xy_r, max_z_r;
  vasl_pkg::vel_t          cur_vx_r, cur_vy_r, cur_vz_r;

  // captured input word
  logic                    op_r;
  vasl_pkg::vel_t          tx_r, ty_r, tz_r;

  // differences and shift registers
  logic [DIFF_W-1:0]       dx_r, dy_r, dz_r;
  logic                    k_r;
  logic [ABS_W-1:0]        as_sr_r, bs_sr_r;
  logic [SQ_W-1:0]         as_ls_r, bs_ls_r;
  logic [SQ_W-1:0]         sq_r;
  logic [STEP_W-1:0]       lim_sr_r;
  logic [PROD_W-1:0]       a_ls_r, b_ls_r;
  logic [PROD_W-1:0]       px_r, py_r;
  logic [ABS_W-1:0]        root_r;
  logic [REM_W-1:0]        srem_r;
  logic [MAG_W-1:0]        mag_r;
  logic                    xy_lim_r;
  logic [REM_W-1:0]        rx_r, ry_r;
  logic [ABS_W-1:0]        qx_r, qy_r;

  // output register
  logic                    out_valid_r;
  vasl_pkg::vel_t          out_vx_r, out_vy_r, out_vz_r;
  logic                    out_xy_r, out_z_r;

  logic                    in_fire;
  logic                    commit;
  logic                    last_mul, last_iter;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid & in_ready;
  assign commit   = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign last_mul  = (cnt_r == CNT_W'(vasl_pkg::MUL_N - 1));
  assign last_iter = (cnt_r == CNT_W'(ABS_W - 1));

  // Differences and magnitudes
  logic [DIFF_W-1:0]       dx_c, dy_c, dz_c;
  logic [ABS_W-1:0]        a_c, b_c;
  logic [KX_W-1:0]         a_ext, b_ext;
  logic                    k_c;

  always_comb begin
    dx_c  = {tx_r[VEL_W-1], tx_r} - {cur_vx_r[VEL_W-1], cur_vx_r};
    dy_c  = {ty_r[VEL_W-1], ty_r} - {cur_vy_r[VEL_W-1], cur_vy_r};
    dz_c  = {tz_r[VEL_W-1], tz_r} - {cur_vz_r[VEL_W-1], cur_vz_r};
    a_c   = dx_c[DIFF_W-1] ? (~dx_c + 1'b1) : dx_c;
    b_c   = dy_c[DIFF_W-1] ? (~dy_c + 1'b1) : dy_c;
    a_ext = KX_W'(a_c);
    b_ext = KX_W'(b_c);
    // halve both before squaring when either reaches 2^31
    k_c   = (|a_ext[KX_W-1:31]) | (|b_ext[KX_W-1:31]);
  end

  // Square-root digit step: two radicand bits per cycle
  logic [SQT_W-1:0]        sq_t, sq_trial;
  logic                    sq_take;

  always_comb begin
    sq_t     = {srem_r, sq_r[SQ_W-1 -: 2]};
    sq_trial = SQT_W'({root_r, 2'b01});
    sq_take  = (sq_t >= sq_trial);
  end

  // Divider steps, one quotient bit per cycle for x and y
  logic [DVT_W-1:0]        dvx_t, dvy_t, dv_mag;
  logic                    dvx_take, dvy_take;

  always_comb begin
    dvx_t    = {rx_r, qx_r[ABS_W-1]};
    dvy_t    = {ry_r, qy_r[ABS_W-1]};
    dv_mag   = DVT_W'(mag_r);
    dvx_take = (dvx_t >= dv_mag);
    dvy_take = (dvy_t >= dv_mag);
  end

  // Magnitude check
  logic [MAG_W-1:0]        mag_c;
  logic                    lim_c;

  always_comb begin
    mag_c = MAG_W'(root_r) << k_r;
    lim_c = (LIM_W'(mag_c) > LIM_W'(max_xy_r));
  end

  // Final step, sum and saturation
  logic signed [SUM_W-1:0] stx, sty, stz, sumx, sumy, sumz;
  logic signed [CMP_W-1:0] dz_w, zl_w;
  logic                    z_hi, z_lo;
  vasl_pkg::vel_t          new_vx, new_vy, new_vz;
  logic                    new_xy, new_z;

  always_comb begin
    // horizontal: scaled quotient with the sign of the difference, or d itself
    if (xy_lim_r) begin
      stx = dx_r[DIFF_W-1] ? -$signed(SUM_W'(qx_r)) : $signed(SUM_W'(qx_r));
      sty = dy_r[DIFF_W-1] ? -$signed(SUM_W'(qy_r)) : $signed(SUM_W'(qy_r));
    end else begin
      stx = SUM_W'($signed(dx_r));
      sty = SUM_W'($signed(dy_r));
    end
    // vertical clamp to +/- max_step_z
    dz_w = CMP_W'($signed(dz_r));
    zl_w = $signed(CMP_W'(max_z_r));
    z_hi = (dz_w > zl_w);
    z_lo = (dz_w < -zl_w);
    priority if (z_hi) begin
      stz = SUM_W'(zl_w);
    end else if (z_lo) begin
      stz = SUM_W'(-zl_w);
    end else begin
      stz = SUM_W'(dz_w);
    end
    sumx = SUM_W'(cur_vx_r) + stx;
    sumy = SUM_W'(cur_vy_r) + sty;
    sumz = SUM_W'(cur_vz_r) + stz;
    if (op_r == vasl_pkg::OP_LOAD) begin
      new_vx = tx_r;
      new_vy = ty_r;
      new_vz = tz_r;
      new_xy = 1'b0;
      new_z  = 1'b0;
    end else begin
      new_vx = vasl_pkg::sat_vel(sumx);
      new_vy = vasl_pkg::sat_vel(sumy);
      new_vz = vasl_pkg::sat_vel(sumz);
      new_xy = xy_lim_r;
      new_z  = z_hi | z_lo;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        cnt_nxt   = '0;
        state_nxt = (op_r == vasl_pkg::OP_LOAD) ? S_FIN : S_MUL;
      end
      S_MUL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last_mul) begin
          cnt_nxt   = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last_iter) begin
          cnt_nxt   = '0;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        state_nxt = lim_c ? S_DIV : S_FIN;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last_iter) begin
          cnt_nxt   = '0;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  // Control registers, limits and stored velocity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      max_xy_r    <= '0;
      max_z_r     <= '0;
      cur_vx_r    <= '0;
      cur_vy_r    <= '0;
      cur_vz_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          vasl_pkg::REG_MAX_STEP_XY: max_xy_r <= cfg_wdata;
          vasl_pkg::REG_MAX_STEP_Z:  max_z_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (commit) begin
        cur_vx_r    <= new_vx;
        cur_vy_r    <= new_vy;
        cur_vz_r    <= new_vz;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= in_opcode;
      tx_r <= in_target_vx;
      ty_r <= in_target_vy;
      tz_r <= in_target_vz;
    end
    unique case (state_r)
      S_DIFF: begin
        dx_r     <= dx_c;
        dy_r     <= dy_c;
        dz_r     <= dz_c;
        k_r      <= k_c;
        as_sr_r  <= a_c >> k_c;
        bs_sr_r  <= b_c >> k_c;
        as_ls_r  <= SQ_W'(a_c >> k_c);
        bs_ls_r  <= SQ_W'(b_c >> k_c);
        a_ls_r   <= PROD_W'(a_c);
        b_ls_r   <= PROD_W'(b_c);
        lim_sr_r <= max_xy_r;
        sq_r     <= '0;
        px_r     <= '0;
        py_r     <= '0;
        root_r   <= '0;
        srem_r   <= '0;
        xy_lim_r <= 1'b0;
      end
      S_MUL: begin
        // shift-add: squares and |d| * max_step_xy, one multiplier bit a cycle
        sq_r     <= sq_r + (as_sr_r[0] ? as_ls_r : '0) + (bs_sr_r[0] ? bs_ls_r : '0);
        px_r     <= px_r + (lim_sr_r[0] ? a_ls_r : '0);
        py_r     <= py_r + (lim_sr_r[0] ? b_ls_r : '0);
        as_sr_r  <= as_sr_r >> 1;
        bs_sr_r  <= bs_sr_r >> 1;
        as_ls_r  <= as_ls_r << 1;
        bs_ls_r  <= bs_ls_r << 1;
        lim_sr_r <= lim_sr_r >> 1;
        a_ls_r   <= a_ls_r << 1;
        b_ls_r   <= b_ls_r << 1;
      end
      S_SQRT: begin
        sq_r   <= sq_r << 2;
        srem_r <= sq_take ? REM_W'(sq_t - sq_trial) : REM_W'(sq_t);
        root_r <= {root_r[ABS_W-2:0], sq_take};
      end
      S_CHK: begin
        // quotient stays below 2^ABS_W, so the high product bits seed the remainder
        mag_r    <= mag_c;
        xy_lim_r <= lim_c;
        rx_r     <= REM_W'(px_r >> ABS_W);
        ry_r     <= REM_W'(py_r >> ABS_W);
        qx_r     <= px_r[ABS_W-1:0];
        qy_r     <= py_r[ABS_W-1:0];
      end
      S_DIV: begin
        rx_r <= dvx_take ? REM_W'(dvx_t - dv_mag) : REM_W'(dvx_t);
        ry_r <= dvy_take ? REM_W'(dvy_t - dv_mag) : REM_W'(dvy_t);
        qx_r <= {qx_r[ABS_W-2:0], dvx_take};
        qy_r <= {qy_r[ABS_W-2:0], dvy_take};
      end
      default: ;
    endcase
    if (commit) begin
      out_vx_r <= new_vx;
      out_vy_r <= new_vy;
      out_vz_r <= new_vz;
      out_xy_r <= new_xy;
      out_z_r  <= new_z;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_vx         = out_vx_r;
  assign out_vy         = out_vy_r;
  assign out_vz         = out_vz_r;
  assign out_xy_limited = out_xy_r;
  assign out_z_limited  = out_z_r;

`ifndef SYNTH
  // divide only runs against a magnitude above the limit, so never by zero
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (mag_r != '0) && (LIM_W'(mag_r) > LIM_W'(max_xy_r)))
    else $error("divide entered with magnitude not above limit");

  // iteration counter stays inside the pass length
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT || state_r == S_DIV) |-> (cnt_r <= CNT_W'(ABS_W - 1)))
    else $error("iteration counter overran");

  // a load word reports the loaded x and z velocity with no limit flags
  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && op_r == vasl_pkg::OP_LOAD) |=>
      out_valid && !out_xy_limited && !out_z_limited && (out_vx == tx_r) && (out_vz == tz_r))
    else $error("load word result mismatch");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench for velocity_accel_slew_limiter_core: directed and random words,
// checked against a behavioral predictor of the limiter. Depends on vasl_pkg.
module tb;

  localparam vasl_pkg::vel_t  VEL_MAX   = {1'b0, {(vasl_pkg::VEL_W-1){1'b1}}};
  localparam vasl_pkg::vel_t  VEL_MIN   = {1'b1, {(vasl_pkg::VEL_W-1){1'b0}}};
  localparam vasl_pkg::step_t STEP_MAX  = {vasl_pkg::STEP_W{1'b1}};
  localparam int              CYCLE_CAP = 1500000;
  localparam int              N_PHASES  = 8;
  localparam int              PHASE_LEN = 135;
  localparam int              HOLD_LEN  = 600;

  typedef struct {
    vasl_pkg::vel_t vx;
    vasl_pkg::vel_t vy;
    vasl_pkg::vel_t vz;
    logic           xy_lim;
    logic           z_lim;
  } vel_result_t;

  // Predicts each result word from the stored velocity and the limits
  class vel_slew_scoreboard;
    longint          cur_vx, cur_vy, cur_vz;
    longint unsigned lim_xy, lim_z;
    vel_result_t     expected_q[$];
    int              errors;

    function new();
      cur_vx = 0;
      cur_vy = 0;
      cur_vz = 0;
      lim_xy = 0;
      lim_z  = 0;
      errors = 0;
    endfunction

    function void set_limits(vasl_pkg::step_t xy, vasl_pkg::step_t z);
      lim_xy = xy;
      lim_z  = z;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function longint clip_vel(longint v);
      if (v > longint'(VEL_MAX)) return longint'(VEL_MAX);
      if (v < longint'(VEL_MIN)) return longint'(VEL_MIN);
      return v;
    endfunction

    // sign(d) * floor(|d| * lim_xy / mag), truncating toward zero
    function longint scaled_step(longint d, longint unsigned mag);
      longint unsigned q;
      q = ((d < 0 ? -d : d) * lim_xy) / mag;
      return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Accepted input word: update the velocity and queue the result
    function void note_word(logic op, vasl_pkg::vel_t tx, vasl_pkg::vel_t ty,
                            vasl_pkg::vel_t tz);
      longint          dx, dy, dz, zl;
      longint unsigned a, b, rem, root, probe, mag;
      int              shift;
      vel_result_t     res;
      res.xy_lim = 1'b0;
      res.z_lim  = 1'b0;
      if (op == vasl_pkg::OP_LOAD) begin
        cur_vx = tx;
        cur_vy = ty;
        cur_vz = tz;
      end else begin
        dx = longint'(tx) - cur_vx;
        dy = longint'(ty) - cur_vy;
        dz = longint'(tz) - cur_vz;
        a = (dx < 0) ? -dx : dx;
        b = (dy < 0) ? -dy : dy;
        shift = (a >= (64'd1 << 31) || b >= (64'd1 << 31)) ? 1 : 0;
        // floor square root, one result bit per pass
        rem   = (a >> shift) * (a >> shift) + (b >> shift) * (b >> shift);
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > rem) probe >>= 2;
        while (probe != 0) begin
          if (rem >= root + probe) begin
            rem  = rem - (root + probe);
            root = (root >> 1) + probe;
          end else begin
            root = root >> 1;
          end
          probe >>= 2;
        end
        mag = root << shift;
        if (mag > lim_xy) begin
          res.xy_lim = 1'b1;
          dx = scaled_step(dx, mag);
          dy = scaled_step(dy, mag);
        end
        zl = longint'(lim_z);
        if (dz > zl) begin
          dz = zl;
          res.z_lim = 1'b1;
        end else if (dz < -zl) begin
          dz = -zl;
          res.z_lim = 1'b1;
        end
        cur_vx = clip_vel(cur_vx + dx);
        cur_vy = clip_vel(cur_vy + dy);
        cur_vz = clip_vel(cur_vz + dz);
      end
      res.vx = vasl_pkg::vel_t'(cur_vx);
      res.vy = vasl_pkg::vel_t'(cur_vy);
      res.vz = vasl_pkg::vel_t'(cur_vz);
      expected_q.push_back(res);
    endfunction

    function void compare_field(string name, logic signed [31:0] exp_v,
                                logic signed [31:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(vasl_pkg::vel_t vx, vasl_pkg::vel_t vy,
                               vasl_pkg::vel_t vz, logic xyl, logic zl);
      vel_result_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected (vx %0d vy %0d vz %0d)",
                 $time, vx, vy, vz);
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("vx", exp_r.vx, vx);
      compare_field("vy", exp_r.vy, vy);
      compare_field("vz", exp_r.vz, vz);
      compare_field("xy_limited", {31'd0, exp_r.xy_lim}, {31'd0, xyl});
      compare_field("z_limited", {31'd0, exp_r.z_lim}, {31'd0, zl});
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [vasl_pkg::CFG_IDX_W-1:0] cfg_index = vasl_pkg::REG_MAX_STEP_XY;
  vasl_pkg::step_t                cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           in_opcode = vasl_pkg::OP_STEP;
  vasl_pkg::vel_t                 in_target_vx = '0;
  vasl_pkg::vel_t                 in_target_vy = '0;
  vasl_pkg::vel_t                 in_target_vz = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  vasl_pkg::vel_t                 out_vx, out_vy, out_vz;
  logic                           out_xy_limited, out_z_limited;

  bit                             idle_en = 1'b1;
  bit                             hold_off_req = 1'b0;
  vel_slew_scoreboard             sb = new();

  velocity_accel_slew_limiter_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_target_vx   (in_target_vx),
    .in_target_vy   (in_target_vy),
    .in_target_vz   (in_target_vz),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_vx         (out_vx),
    .out_vy         (out_vy),
    .out_vz         (out_vz),
    .out_xy_limited (out_xy_limited),
    .out_z_limited  (out_z_limited)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Writes both limit registers on back-to-back edges; block must be idle
  task automatic set_limits(input vasl_pkg::step_t xy, input vasl_pkg::step_t z);
    cfg_we    <= 1'b1;
    cfg_index <= vasl_pkg::REG_MAX_STEP_XY;
    cfg_wdata <= xy;
    @(posedge clk);
    cfg_index <= vasl_pkg::REG_MAX_STEP_Z;
    cfg_wdata <= z;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_limits(xy, z);
  endtask

  // Offers one word, waits for acceptance, then maybe idles
  task automatic send_word(input logic op, input vasl_pkg::vel_t tx,
                           input vasl_pkg::vel_t ty, input vasl_pkg::vel_t tz);
    int r, gap;
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_target_vx <= tx;
    in_target_vy <= ty;
    in_target_vz <= tz;
    do @(posedge clk); while (!in_ready);
    sb.note_word(op, tx, ty, tz);
    r = $urandom_range(0, 99);
    if (!idle_en || r < 60) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 4);
    else if (r < 97) gap = $urandom_range(5, 20);
    else gap = $urandom_range(40, 150);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender pause: drop valid and let every expected word come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic vasl_pkg::step_t pick_limit();
    int r, w;
    r = $urandom_range(0, 9);
    w = $urandom_range(1, vasl_pkg::STEP_W);
    if (r == 0) return '0;
    if (r == 1) return STEP_MAX;
    return vasl_pkg::step_t'($urandom_range(0, (32'd1 << w) - 1));
  endfunction

  // One target axis: near the current value (step words only), anywhere, or at an extreme or near zero
  function automatic vasl_pkg::vel_t rand_axis(longint base, bit stepping);
    int     r, w;
    longint delta, v;
    r = $urandom_range(0, 99);
    if (stepping && r < 50) begin
      w     = $urandom_range(0, 23);
      delta = longint'($urandom_range(0, (32'd1 << w) - 1));
      if ($urandom_range(0, 1)) delta = -delta;
      v = base + delta;
      if (v > longint'(VEL_MAX)) v = longint'(VEL_MAX);
      if (v < longint'(VEL_MIN)) v = longint'(VEL_MIN);
      return vasl_pkg::vel_t'(v);
    end
    if (r < 85) return vasl_pkg::vel_t'($urandom);
    case ($urandom_range(0, 4))
      0: return VEL_MAX;
      1: return VEL_MIN;
      2: return vasl_pkg::vel_t'(0);
      3: return vasl_pkg::vel_t'(-1);
      default: return vasl_pkg::vel_t'(1);
    endcase
  endfunction

  // Result side: check accepted words, stall at random or on request
  initial begin : result_side
    int stall_left, r;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else begin
        if (out_valid && out_ready)
          sb.check_result(out_vx, out_vy, out_vz, out_xy_limited, out_z_limited);
        if (hold_off_req) begin
          hold_off_req = 1'b0;
          stall_left   = HOLD_LEN;
        end
        r = $urandom_range(0, 99);
        if (stall_left > 0) begin
          stall_left--;
          out_ready <= 1'b0;
        end else if (idle_en && r < 8) begin
          stall_left = $urandom_range(0, 3);
          out_ready <= 1'b0;
        end else if (idle_en && r == 8) begin
          stall_left = $urandom_range(30, 120);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Timeout
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_CAP) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int             r;
    logic           op;
    vasl_pkg::vel_t tx, ty, tz;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero limits: any change collapses to a zero step
    set_limits('0, '0);
    send_word(vasl_pkg::OP_STEP, 0, 0, 0);
    send_word(vasl_pkg::OP_STEP, VEL_MAX, VEL_MIN, VEL_MAX);
    send_word(vasl_pkg::OP_LOAD, VEL_MAX, VEL_MAX, VEL_MIN);
    send_word(vasl_pkg::OP_STEP, VEL_MAX, VEL_MAX, VEL_MIN);
    wait_drain();

    // widest limits, largest possible changes
    set_limits(STEP_MAX, STEP_MAX);
    send_word(vasl_pkg::OP_STEP, VEL_MIN, VEL_MIN, VEL_MAX);
    send_word(vasl_pkg::OP_LOAD, VEL_MIN, VEL_MAX, 0);
    send_word(vasl_pkg::OP_STEP, VEL_MAX, VEL_MIN, VEL_MIN);
    send_word(vasl_pkg::OP_STEP, 0, 0, 0);
    send_word(vasl_pkg::OP_LOAD, -1, 1, -1);
    send_word(vasl_pkg::OP_STEP, 1, -1, 1);
    wait_drain();

    // magnitude right at the limit, then over it
    set_limits(23'd500, 23'd100);
    send_word(vasl_pkg::OP_LOAD, 0, 0, 0);
    send_word(vasl_pkg::OP_STEP, 300, 400, 100);
    send_word(vasl_pkg::OP_STEP, 900, -400, 201);
    send_word(vasl_pkg::OP_STEP, -5000, 7, -3000);
    send_word(vasl_pkg::OP_STEP, 600, 0, 200);
    send_word(vasl_pkg::OP_LOAD, VEL_MIN, 0, VEL_MAX);
    send_word(vasl_pkg::OP_STEP, VEL_MIN, 1, VEL_MAX);
    wait_drain();

    // unit limits: truncation of scaled components
    set_limits(23'd1, 23'd1);
    send_word(vasl_pkg::OP_STEP, VEL_MAX, VEL_MAX, VEL_MIN);
    send_word(vasl_pkg::OP_STEP, VEL_MIN, 0, VEL_MIN);
    send_word(vasl_pkg::OP_LOAD, 0, 0, 0);
    send_word(vasl_pkg::OP_STEP, 1, 0, -1);
    send_word(vasl_pkg::OP_STEP, 2, 2, 3);

    // random phases, each with its own limits
    for (int phase = 0; phase < N_PHASES; phase++) begin
      wait_drain();
      idle_en = (phase != 0);
      if (phase == 0) set_limits(STEP_MAX, STEP_MAX);
      else if (phase == 1) set_limits('0, '0);
      else set_limits(pick_limit(), pick_limit());
      for (int i = 0; i < PHASE_LEN; i++) begin
        if (phase == 3 && i == 20) hold_off_req = 1'b1;
        r  = $urandom_range(0, 99);
        op = (r < 15) ? vasl_pkg::OP_LOAD : vasl_pkg::OP_STEP;
        tx = rand_axis(sb.cur_vx, op == vasl_pkg::OP_STEP);
        ty = rand_axis(sb.cur_vy, op == vasl_pkg::OP_STEP);
        tz = rand_axis(sb.cur_vz, op == vasl_pkg::OP_STEP);
        send_word(op, tx, ty, tz);
      end
    end

    wait_drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
